### rtl/core/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg: PETSCII control decoder shared definitions
// Command codes, the decode result bundle and screen code constants.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // display command codes
  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_FGCOLOR   = 4'd1,
    CMD_NEWLINE   = 4'd2,
    CMD_DOWN      = 4'd3,
    CMD_HOME      = 4'd4,
    CMD_CLEARHOME = 4'd5,
    CMD_DELETE    = 4'd6,
    CMD_INSERT    = 4'd7,
    CMD_LEFT      = 4'd8,
    CMD_RIGHT     = 4'd9,
    CMD_UP        = 4'd10,
    CMD_FONT      = 4'd11,
    CMD_BELL      = 4'd12,
    CMD_DRAW      = 4'd13
  } pcd_cmd_e;

  // font numbers carried in arg
  localparam logic [7:0] FontLower = 8'd1;
  localparam logic [7:0] FontUpper = 8'd0;

  // screen code for the pi character
  localparam logic [6:0] ScreenPi = 7'd94;

  // result of decoding one byte, with the state it leaves behind
  typedef struct packed {
    pcd_cmd_e   cmd;
    logic [7:0] arg;
    logic       reverse_d;
    logic       shift_cbm_d;
  } pcd_dec_t;

endpackage

### rtl/core/pcd_decode.sv
// ----------------------------------------------------------------------------
// pcd_decode: PETSCII byte decode logic
// Case swap, colour table, control code map and screen code bands, all in
// one short combinational pass.
// ----------------------------------------------------------------------------
module pcd_decode
  import pcd_pkg::*;
(
  input  logic       case_swap_i,
  input  logic [7:0] code_i,
  input  logic       reverse_i,
  input  logic       shift_cbm_i,
  output pcd_dec_t   dec_o
);

  logic [7:0] code_sw;
  logic [6:0] screen;
  logic [3:0] colour;
  logic       is_colour;

  // optional letter case exchange
  always_comb begin
    code_sw = code_i;
    if (case_swap_i) begin
      if (code_i inside {[8'd65:8'd90]}) begin
        code_sw = code_i + 8'd32;
      end else if (code_i inside {[8'd97:8'd122]}) begin
        code_sw = code_i - 8'd32;
      end
    end
  end

  // colour codes to palette index
  always_comb begin
    is_colour = 1'b1;
    case (code_sw)
      8'd5:    colour = 4'd1;
      8'd28:   colour = 4'd2;
      8'd30:   colour = 4'd5;
      8'd31:   colour = 4'd6;
      8'd129:  colour = 4'd8;
      8'd144:  colour = 4'd0;
      8'd149:  colour = 4'd9;
      8'd150:  colour = 4'd10;
      8'd151:  colour = 4'd11;
      8'd152:  colour = 4'd12;
      8'd153:  colour = 4'd13;
      8'd154:  colour = 4'd14;
      8'd155:  colour = 4'd15;
      8'd156:  colour = 4'd4;
      8'd158:  colour = 4'd7;
      8'd159:  colour = 4'd3;
      default: begin
        colour    = 4'd0;
        is_colour = 1'b0;
      end
    endcase
  end

  // screen code bands, always below 128
  always_comb begin
    if (code_sw == 8'd255) begin
      screen = ScreenPi;
    end else if (code_sw < 8'd64) begin
      screen = code_sw[6:0];
    end else if (code_sw < 8'd96) begin
      screen = 7'(code_sw - 8'd64);
    end else if (code_sw < 8'd128) begin
      screen = 7'(code_sw - 8'd32);
    end else if (code_sw < 8'd192) begin
      screen = 7'(code_sw - 8'd64);
    end else begin
      screen = 7'(code_sw - 8'd128);
    end
  end

  // command selection and state update
  always_comb begin
    dec_o.cmd         = CMD_NONE;
    dec_o.arg         = 8'd0;
    dec_o.reverse_d   = reverse_i;
    dec_o.shift_cbm_d = shift_cbm_i;
    if (is_colour) begin
      dec_o.cmd = CMD_FGCOLOR;
      dec_o.arg = {4'd0, colour};
    end else begin
      case (code_sw)
        8'd13, 8'd141: begin
          dec_o.reverse_d = 1'b0;
          dec_o.cmd       = CMD_NEWLINE;
        end
        8'd17:  dec_o.cmd = CMD_DOWN;
        8'd147: dec_o.cmd = CMD_CLEARHOME;
        8'd19:  dec_o.cmd = CMD_HOME;
        8'd20:  dec_o.cmd = CMD_DELETE;
        8'd157: dec_o.cmd = CMD_LEFT;
        8'd29:  dec_o.cmd = CMD_RIGHT;
        8'd145: dec_o.cmd = CMD_UP;
        8'd148: dec_o.cmd = CMD_INSERT;
        8'd8:   dec_o.shift_cbm_d = 1'b0;
        8'd9:   dec_o.shift_cbm_d = 1'b1;
        8'd14: begin
          dec_o.cmd = CMD_FONT;
          dec_o.arg = FontLower;
        end
        8'd142: begin
          dec_o.cmd = CMD_FONT;
          dec_o.arg = FontUpper;
        end
        8'd18:  dec_o.reverse_d = 1'b1;
        8'd146: dec_o.reverse_d = 1'b0;
        8'd7:   dec_o.cmd = CMD_BELL;
        default: begin
          if (code_sw inside {[8'd32:8'd127], [8'd160:8'd255]}) begin
            dec_o.cmd = CMD_DRAW;
            dec_o.arg = {reverse_i, screen};
          end
        end
      endcase
    end
  end

endmodule

### rtl/core/petscii_control_decoder_unit.sv
// ----------------------------------------------------------------------------
// petscii_control_decoder_unit: PETSCII terminal output decoder
// Turns each PETSCII byte into one display command, tracking reverse mode
// and the shift plus C= font toggle enable.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   input    | in        | in_valid_i/in_ready_o  | code_i
//   output   | out       | out_valid_o/out_ready_i| cmd_o, arg_o,
//            |           |                        | shift_cbm_enabled_o
//   config   | in        | cfg_we_i (no wait)     | cfg_wdata_i (case swap)
//
// One request per cycle while the output is not stalled; each passes from
// acceptance through the input register and then the result register.
// Decode and state update happen as a request moves from the input register
// into the result register; reverse and shift+C= state sit beside that step.
// A stalled output holds the result register; the input register then fills
// and in_ready_o drops. Reset clears both valid flags and reverse mode, and sets the shift+C= enable.
// ----------------------------------------------------------------------------
module petscii_control_decoder_unit
  import pcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] cmd_o,
  output logic [7:0] arg_o,
  output logic       shift_cbm_enabled_o
);

  logic       case_swap_q;
  logic       in_valid_q;
  logic [7:0] code_q;
  logic       out_valid_q;
  pcd_cmd_e   cmd_q;
  logic [7:0] arg_q;
  logic       reverse_q;
  logic       shift_cbm_q;
  logic       res_ready;
  logic       advance;
  pcd_dec_t   dec;

  // pipeline handshake
  assign res_ready  = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && res_ready;
  assign in_ready_o = !in_valid_q || res_ready;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_swap_q <= 1'b0;
    end else if (cfg_we_i) begin
      case_swap_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      code_q <= code_i;
    end
  end

  // decode logic
  pcd_decode u_decode (
    .case_swap_i (case_swap_q),
    .code_i      (code_q),
    .reverse_i   (reverse_q),
    .shift_cbm_i (shift_cbm_q),
    .dec_o       (dec)
  );

  // mode state, updated as each request is decoded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q   <= 1'b0;
      shift_cbm_q <= 1'b1;
    end else if (advance) begin
      reverse_q   <= dec.reverse_d;
      shift_cbm_q <= dec.shift_cbm_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd_q <= dec.cmd;
      arg_q <= dec.arg;
    end
  end

  // outputs; the enable flag shown is the one after this request
  logic shift_out_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      shift_out_q <= dec.shift_cbm_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign cmd_o               = cmd_q;
  assign arg_o               = arg_q;
  assign shift_cbm_enabled_o = shift_out_q;

endmodule

### rtl/core/pcd_checker.sv
// ----------------------------------------------------------------------------
// pcd_checker: port level checks for the PETSCII control decoder
// Watches the handshakes and result payload of the top level.
// ----------------------------------------------------------------------------
module pcd_checker
  import pcd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] cmd_o,
  input logic [7:0] arg_o
);

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cmd_o) && $stable(arg_o))
    else $error("stalled result changed");

  // only defined command codes appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cmd_o <= CMD_DRAW)
    else $error("undefined command code");

  // commands without argument carry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cmd_o != CMD_FGCOLOR && cmd_o != CMD_FONT && cmd_o != CMD_DRAW
    |-> arg_o == 8'd0)
    else $error("non-zero argument on plain command");

  // colour index and font number stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cmd_o == CMD_FGCOLOR || cmd_o == CMD_FONT)
    |-> arg_o[7:4] == 4'd0 && (cmd_o == CMD_FGCOLOR || arg_o[3:1] == 3'd0))
    else $error("argument out of range");

  // an accepted request always yields a result, through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("request lost");

endmodule

bind petscii_control_decoder_unit pcd_checker u_pcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .cmd_o       (cmd_o),
  .arg_o       (arg_o)
);
